/* hw/rtl/env_sensor_compensation_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the environmental sensor compensation unit
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

`ifndef SYNTH
`define ESCU_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ESCU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ESCU_ASSERT(lbl, ante, cons)
`define ESCU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/escu_pkg.sv */
// ----------------------------------------------------------------------------
// Compensation unit package
// Shared types, constants and the divider step.
// ----------------------------------------------------------------------------
package escu_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned DivBits    = 64;
  localparam int unsigned CfgAddrW   = 6;
  localparam int unsigned HumMax     = 419430400;

  typedef enum logic [2:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_PRESS_C = 3'd3,
    REG_CAL_HUM     = 3'd4
  } escu_reg_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [47:0] press_a;
    logic [47:0] press_b;
    logic [47:0] press_c;
    logic [63:0] hum;
  } escu_cal_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        invalid;
  } escu_item_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] den;
    logic        neg;
    logic [31:0] temp;
    logic [16:0] hum;
    logic        invalid;
  } escu_div_t;

  function automatic escu_div_t escu_div_step(escu_div_t s);
    escu_div_t   o;
    logic [64:0] tmp;
    logic [64:0] dif;
    logic        ge;
    o   = s;
    tmp = {s.rem, s.num[63]};
    dif = tmp - {1'b0, s.den};
    ge  = (tmp >= {1'b0, s.den});
    o.rem = ge ? dif[63:0] : tmp[63:0];
    o.num = {s.num[62:0], ge};
    return o;
  endfunction

endpackage

/* hw/rtl/env_sensor_compensation_unit.sv */
// ----------------------------------------------------------------------------
// Environmental sensor compensation unit
// Integer compensation of raw temperature, pressure and humidity.
// ----------------------------------------------------------------------------
//  Channel  Signals                                  Direction
//  in       in_valid/in_ready, raw T/P/H             into the unit
//  out      out_valid/out_ready, T/P/H, invalid      out of the unit
//  cfg      psel/penable/pwrite/paddr/pwdata/prdata  APB calibration access
//
//  One item is accepted per cycle while the output side keeps up.
//  When nothing stalls, an item passes through 11 front stages, the queue,
//  one divider setup stage, 64 divider stages, 3 correction stages and the
//  output register. The 64-stage divider sets the depth of the back end.
//  Reset is synchronous and clears the calibration registers.
//  A stalled output freezes the back end; the queue lets the front end keep
//  accepting until it is full.
// ----------------------------------------------------------------------------
module env_sensor_compensation_unit #(
  parameter int unsigned QDepth = escu_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [19:0]                   in_raw_temperature,
  input  logic [19:0]                   in_raw_pressure,
  input  logic [15:0]                   in_raw_humidity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_temperature_centi,
  output logic [31:0]                   out_pressure_q24_8,
  output logic [16:0]                   out_humidity_q22_10,
  output logic                          out_pressure_invalid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escu_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import escu_pkg::*;

  escu_cal_t  cal;
  escu_item_t push_item, head;
  logic       push, pop, full, empty;

  escu_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cal
  );

  escu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_raw_temperature, .in_raw_pressure,
    .in_raw_humidity, .cal, .full_i(full), .push_o(push), .push_item_o(push_item)
  );

  escu_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .push_i(push), .push_item_i(push_item), .pop_i(pop),
    .head_o(head), .full_o(full), .empty_o(empty)
  );

  escu_back u_back (
    .clk, .rst_n, .cal, .head_i(head), .empty_i(empty), .pop_o(pop), .out_valid,
    .out_ready, .out_temperature_centi, .out_pressure_q24_8, .out_humidity_q22_10,
    .out_pressure_invalid
  );

endmodule

/* hw/rtl/escu_regs.sv */
// ----------------------------------------------------------------------------
// Calibration register file
// APB-style access to the five calibration registers.
// ----------------------------------------------------------------------------
module escu_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escu_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  output escu_pkg::escu_cal_t           cal
);
  import escu_pkg::*;

  escu_cal_t cal_r;
  escu_reg_t idx;

  assign idx    = escu_reg_t'(paddr[CfgAddrW-1:3]);
  assign pready = 1'b1;
  assign cal    = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_CAL_TEMP:    cal_r.temp    <= pwdata[47:0];
        REG_CAL_PRESS_A: cal_r.press_a <= pwdata[47:0];
        REG_CAL_PRESS_B: cal_r.press_b <= pwdata[47:0];
        REG_CAL_PRESS_C: cal_r.press_c <= pwdata[47:0];
        REG_CAL_HUM:     cal_r.hum     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAL_TEMP:    prdata = {16'd0, cal_r.temp};
      REG_CAL_PRESS_A: prdata = {16'd0, cal_r.press_a};
      REG_CAL_PRESS_B: prdata = {16'd0, cal_r.press_b};
      REG_CAL_PRESS_C: prdata = {16'd0, cal_r.press_c};
      REG_CAL_HUM:     prdata = cal_r.hum;
      default:         prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/escu_front.sv */
// ----------------------------------------------------------------------------
// Compensation front end
// Eleven-stage pipeline: fine temperature, temperature, humidity and the
// pressure dividend and divisor.
// ----------------------------------------------------------------------------
module escu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [19:0]          in_raw_temperature,
  input  logic [19:0]          in_raw_pressure,
  input  logic [15:0]          in_raw_humidity,
  input  escu_pkg::escu_cal_t  cal,
  input  logic                 full_i,
  output logic                 push_o,
  output escu_pkg::escu_item_t push_item_o
);
  import escu_pkg::*;

  logic [10:0] vld_r;
  logic        en;

  logic [15:0]        t1;
  logic signed [31:0] t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = cal.temp[15:0];
  assign t2 = {{16{cal.temp[31]}}, cal.temp[31:16]};
  assign t3 = {{16{cal.temp[47]}}, cal.temp[47:32]};
  assign p1 = {48'd0, cal.press_a[15:0]};
  assign p2 = {{48{cal.press_a[31]}}, cal.press_a[31:16]};
  assign p3 = {{48{cal.press_a[47]}}, cal.press_a[47:32]};
  assign p4 = {{48{cal.press_b[15]}}, cal.press_b[15:0]};
  assign p5 = {{48{cal.press_b[31]}}, cal.press_b[31:16]};
  assign p6 = {{48{cal.press_b[47]}}, cal.press_b[47:32]};
  assign h1 = {24'd0, cal.hum[7:0]};
  assign h2 = {{16{cal.hum[23]}}, cal.hum[23:8]};
  assign h3 = {24'd0, cal.hum[31:24]};
  assign h4 = {{20{cal.hum[43]}}, cal.hum[43:32]};
  assign h5 = {{20{cal.hum[55]}}, cal.hum[55:44]};
  assign h6 = {{24{cal.hum[63]}}, cal.hum[63:56]};

  assign en       = !(vld_r[10] && full_i);
  assign in_ready = en;
  assign push_o   = vld_r[10] && !full_i;

  logic signed [31:0] a_c, b_c, t5_c, hx_c, s_c, sq_c, hv_c, hc_c;
  logic signed [63:0] num_c;

  logic signed [31:0] s1_m1_r, s1_bb_r, s2_tv1_r, s2_c_r, s3_tfine_r;
  logic [19:0]        s1_rp_r, s2_rp_r, s3_rp_r, s4_rp_r, s5_rp_r, s6_rp_r, s7_rp_r, s8_rp_r;
  logic [15:0]        s1_rh_r, s2_rh_r, s3_rh_r, s4_rh_r;
  logic [31:0]        s4_temp_r, s5_temp_r, s6_temp_r, s7_temp_r, s8_temp_r, s9_temp_r;
  logic [31:0]        s10_temp_r, s11_temp_r;
  logic signed [63:0] s4_v1_r, s5_sq_r, s5_m5_r, s5_m2_r, s6_v2a_r, s6_v1a_r, s6_m5_r, s6_m2_r;
  logic signed [63:0] s7_v2_r, s7_v1b_r, s8_prod_r, s8_v2_r, s9_dv_r, s9_num_r;
  logic signed [63:0] s10_dividend_r, s10_divisor_r, s11_dividend_r, s11_divisor_r;
  logic               s10_inv_r, s11_inv_r;
  logic signed [31:0] s4_vh_r, s5_x_r, s5_mv6_r, s5_mv3_r, s6_x_r, s6_y1_r, s7_x_r, s7_y2_r;
  logic signed [31:0] s8_x_r, s8_y_r, s9_vv_r, s10_vv_r, s10_w_r;
  logic [16:0]        s11_hum_r;

  always_comb begin
    a_c   = {15'd0, in_raw_temperature[19:3]} - {15'd0, t1, 1'b0};
    b_c   = {16'd0, in_raw_temperature[19:4]} - {16'd0, t1};
    t5_c  = s3_tfine_r * 32'sd5 + 32'sd128;
    hx_c  = $signed({2'b00, s4_rh_r, 14'd0}) - (h4 <<< 20) - s4_vh_r * h5 + 32'sd16384;
    num_c = ((64'sd1048576 - $signed({44'd0, s8_rp_r})) <<< 31) - s8_v2_r;
    s_c   = s9_vv_r >>> 15;
    sq_c  = s_c * s_c;
    hv_c  = s10_vv_r - ((s10_w_r * h1) >>> 4);
    if (hv_c[31]) begin
      hc_c = '0;
    end else if (hv_c > $signed(32'(HumMax))) begin
      hc_c = $signed(32'(HumMax));
    end else begin
      hc_c = hv_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r    <= a_c * t2;
      s1_bb_r    <= b_c * b_c;
      s1_rp_r    <= in_raw_pressure;
      s1_rh_r    <= in_raw_humidity;
      s2_tv1_r   <= s1_m1_r >>> 11;
      s2_c_r     <= (s1_bb_r >>> 12) * t3;
      s2_rp_r    <= s1_rp_r;
      s2_rh_r    <= s1_rh_r;
      s3_tfine_r <= s2_tv1_r + (s2_c_r >>> 14);
      s3_rp_r    <= s2_rp_r;
      s3_rh_r    <= s2_rh_r;
      s4_temp_r  <= t5_c >>> 8;
      s4_v1_r    <= 64'(s3_tfine_r) - 64'sd128000;
      s4_vh_r    <= s3_tfine_r - 32'sd76800;
      s4_rp_r    <= s3_rp_r;
      s4_rh_r    <= s3_rh_r;
      s5_sq_r    <= s4_v1_r * s4_v1_r;
      s5_m5_r    <= s4_v1_r * p5;
      s5_m2_r    <= s4_v1_r * p2;
      s5_x_r     <= hx_c >>> 15;
      s5_mv6_r   <= s4_vh_r * h6;
      s5_mv3_r   <= s4_vh_r * h3;
      s5_rp_r    <= s4_rp_r;
      s5_temp_r  <= s4_temp_r;
      s6_v2a_r   <= s5_sq_r * p6;
      s6_v1a_r   <= s5_sq_r * p3;
      s6_m5_r    <= s5_m5_r;
      s6_m2_r    <= s5_m2_r;
      s6_y1_r    <= (s5_mv6_r >>> 10) * ((s5_mv3_r >>> 11) + 32'sd32768);
      s6_x_r     <= s5_x_r;
      s6_rp_r    <= s5_rp_r;
      s6_temp_r  <= s5_temp_r;
      s7_v2_r    <= s6_v2a_r + (s6_m5_r <<< 17) + (p4 <<< 35);
      s7_v1b_r   <= (s6_v1a_r >>> 8) + (s6_m2_r <<< 12);
      s7_y2_r    <= ((s6_y1_r >>> 10) + 32'sd2097152) * h2;
      s7_x_r     <= s6_x_r;
      s7_rp_r    <= s6_rp_r;
      s7_temp_r  <= s6_temp_r;
      s8_prod_r  <= (64'sh0000_8000_0000_0000 + s7_v1b_r) * p1;
      s8_y_r     <= (s7_y2_r + 32'sd8192) >>> 14;
      s8_x_r     <= s7_x_r;
      s8_v2_r    <= s7_v2_r;
      s8_rp_r    <= s7_rp_r;
      s8_temp_r  <= s7_temp_r;
      s9_dv_r    <= s8_prod_r >>> 33;
      s9_num_r   <= num_c;
      s9_vv_r    <= s8_x_r * s8_y_r;
      s9_temp_r  <= s8_temp_r;
      s10_inv_r      <= (s9_dv_r == 64'sd0);
      s10_dividend_r <= s9_num_r * 64'sd3125;
      s10_divisor_r  <= (s9_dv_r == 64'sd0) ? 64'sd1 : s9_dv_r;
      s10_vv_r       <= s9_vv_r;
      s10_w_r        <= sq_c >>> 7;
      s10_temp_r     <= s9_temp_r;
      s11_inv_r      <= s10_inv_r;
      s11_dividend_r <= s10_dividend_r;
      s11_divisor_r  <= s10_divisor_r;
      s11_hum_r      <= hc_c[28:12];
      s11_temp_r     <= s10_temp_r;
    end
  end

  assign push_item_o.temp     = s11_temp_r;
  assign push_item_o.hum      = s11_hum_r;
  assign push_item_o.dividend = s11_dividend_r;
  assign push_item_o.divisor  = s11_divisor_r;
  assign push_item_o.invalid  = s11_inv_r;

endmodule

/* hw/rtl/escu_queue.sv */
// ----------------------------------------------------------------------------
// Front-to-back queue
// Small register FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_unit_assert.svh"
module escu_queue #(
  parameter int unsigned Depth = escu_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  escu_pkg::escu_item_t push_item_i,
  input  logic                 pop_i,
  output escu_pkg::escu_item_t head_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import escu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  escu_item_t      mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full_o  = (count_r == CntW'(Depth));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  `ESCU_ASSERT(a_no_overflow, 1'b1, count_r <= CntW'(Depth))
  `ESCU_ASSERT_NEXT(a_count_grows, push_i && !pop_i, count_r == $past(count_r) + 1'b1)
  `ESCU_ASSERT(a_pop_nonempty, pop_i, count_r != '0)

endmodule

/* hw/rtl/escu_back.sv */
// ----------------------------------------------------------------------------
// Compensation back end
// Pipelined 64-bit signed divider and pressure correction, with the
// output register.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_unit_assert.svh"
module escu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  escu_pkg::escu_cal_t  cal,
  input  escu_pkg::escu_item_t head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_temperature_centi,
  output logic [31:0]          out_pressure_q24_8,
  output logic [16:0]          out_humidity_q22_10,
  output logic                 out_pressure_invalid
);
  import escu_pkg::*;

  localparam int unsigned NStages = DivBits + 5;

  logic [NStages-1:0] vld_r;
  logic               en;
  escu_div_t          dv_r [DivBits+1];
  escu_div_t          init_c;

  logic signed [63:0] p7, p8, p9, pq_c, pf_c, q13_c;
  logic signed [63:0] p1_p_r, p1_m8_r, p2_p_r, p2_qq_r, p2_v2_r;
  logic [63:0]        p1_qll_r;
  logic [31:0]        p1_qcr_r;
  logic signed [63:0] p3_p_r, p3_v1_r, p3_v2_r;
  logic [31:0]        p1_t_r, p2_t_r, p3_t_r;
  logic [16:0]        p1_h_r, p2_h_r, p3_h_r;
  logic               p1_i_r, p2_i_r, p3_i_r;

  assign p7 = {{48{cal.press_c[15]}}, cal.press_c[15:0]};
  assign p8 = {{48{cal.press_c[31]}}, cal.press_c[31:16]};
  assign p9 = {{48{cal.press_c[47]}}, cal.press_c[47:32]};

  assign out_valid = vld_r[NStages-1];
  assign en        = !vld_r[NStages-1] || out_ready;
  assign pop_o     = en && !empty_i;

  always_comb begin
    init_c.num     = head_i.dividend[63] ? -head_i.dividend : head_i.dividend;
    init_c.den     = head_i.divisor[63] ? -head_i.divisor : head_i.divisor;
    init_c.rem     = '0;
    init_c.neg     = head_i.dividend[63] ^ head_i.divisor[63];
    init_c.temp    = head_i.temp;
    init_c.hum     = head_i.hum;
    init_c.invalid = head_i.invalid;
    pq_c  = dv_r[DivBits].neg ? -$signed(dv_r[DivBits].num) : $signed(dv_r[DivBits].num);
    q13_c = pq_c >>> 13;
    pf_c  = ((p3_p_r + p3_v1_r + p3_v2_r) >>> 8) + (p7 <<< 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NStages-2:0], pop_o};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= init_c;
      for (int k = 0; k < DivBits; k++) begin
        dv_r[k+1] <= escu_div_step(dv_r[k]);
      end
      p1_p_r   <= pq_c;
      p1_qll_r <= 64'(q13_c[31:0]) * 64'(q13_c[31:0]);
      p1_qcr_r <= q13_c[31:0] * q13_c[63:32];
      p1_m8_r  <= pq_c * p8;
      p1_t_r   <= dv_r[DivBits].temp;
      p1_h_r   <= dv_r[DivBits].hum;
      p1_i_r   <= dv_r[DivBits].invalid;
      p2_p_r   <= p1_p_r;
      p2_qq_r  <= p1_qll_r + {p1_qcr_r[30:0], 33'd0};
      p2_v2_r  <= p1_m8_r >>> 19;
      p2_t_r   <= p1_t_r;
      p2_h_r   <= p1_h_r;
      p2_i_r   <= p1_i_r;
      p3_p_r   <= p2_p_r;
      p3_v1_r  <= (p2_qq_r * p9) >>> 25;
      p3_v2_r  <= p2_v2_r;
      p3_t_r   <= p2_t_r;
      p3_h_r   <= p2_h_r;
      p3_i_r   <= p2_i_r;
      out_temperature_centi <= p3_t_r;
      out_humidity_q22_10   <= p3_h_r;
      out_pressure_invalid  <= p3_i_r;
      out_pressure_q24_8    <= p3_i_r ? 32'd0 : pf_c[31:0];
    end
  end

  `ESCU_ASSERT(a_invalid_zero, out_valid && out_pressure_invalid, out_pressure_q24_8 == '0)
  `ESCU_ASSERT(a_hum_range, out_valid, out_humidity_q22_10 <= 17'd102400)
  `ESCU_ASSERT(a_pop_advances, pop_o, en && !empty_i)

endmodule
